[hdl/owm_pkg.sv]
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the one-wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

    localparam int CFG_W = 10;
    localparam int IDX_W = 3;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_RESET = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_RDB   = 3'd3;
    localparam logic [2:0] CMD_RDW   = 3'd4;

    localparam logic [IDX_W-1:0] REG_SLOT_TIME       = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW_TIME_ZERO   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOW_TIME_ONE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_READ_LOW_TIME   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RESET_LOW_TIME  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RESET_HIGH_TIME = 3'd5;
    localparam logic [IDX_W-1:0] REG_PRESENCE_WAIT   = 3'd6;
    localparam logic [IDX_W-1:0] REG_RECOVERY_TIME   = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       bus_in;
    } t_in;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] rx_data;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0] slot_time;
        logic [CFG_W-1:0] low_time_zero;
        logic [CFG_W-1:0] low_time_one;
        logic [CFG_W-1:0] read_low_time;
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] reset_high_time;
        logic [CFG_W-1:0] presence_wait;
        logic [CFG_W-1:0] recovery_time;
    } t_cfg;

endpackage

`default_nettype wire

[hdl/owm_cfg.sv]
// ----------------------------------------------------------------------------
// owm_cfg
// Timing register file of the one-wire bus master, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_cfg
    import owm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_time       <= 10'd70;
            r_cfg.low_time_zero   <= 10'd70;
            r_cfg.low_time_one    <= 10'd10;
            r_cfg.read_low_time   <= 10'd1;
            r_cfg.reset_low_time  <= 10'd500;
            r_cfg.reset_high_time <= 10'd500;
            r_cfg.presence_wait   <= 10'd70;
            r_cfg.recovery_time   <= 10'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SLOT_TIME:       r_cfg.slot_time       <= i_cfg_data;
                REG_LOW_TIME_ZERO:   r_cfg.low_time_zero   <= i_cfg_data;
                REG_LOW_TIME_ONE:    r_cfg.low_time_one    <= i_cfg_data;
                REG_READ_LOW_TIME:   r_cfg.read_low_time   <= i_cfg_data;
                REG_RESET_LOW_TIME:  r_cfg.reset_low_time  <= i_cfg_data;
                REG_RESET_HIGH_TIME: r_cfg.reset_high_time <= i_cfg_data;
                REG_PRESENCE_WAIT:   r_cfg.presence_wait   <= i_cfg_data;
                REG_RECOVERY_TIME:   r_cfg.recovery_time   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hdl/one_wire_bus_master.sv]
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by one microsecond tick per input beat.
//
// Each input beat is one tick: the sampled line level, an optional command
// and the byte to send. Each accepted beat yields exactly one output beat
// with the line drive, busy and done flags and the received data.
// The output beat is registered and appears in the cycle after the input
// beat is accepted; a new input beat is taken every cycle unless input stalls.
// The slot sequencer and its timer update in that same cycle, and the
// result lands in the output register.
// While the receiver stalls a valid output beat, it holds and input stalls;
// an output register that is empty or being read out does not stall input.
// Timing registers are written through the configuration port; the user
// must write them only while idle; the block does not check it. Reset returns
// the sequencer to idle, empties the output register, loads the default timings.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master
    import owm_pkg::*;
#(
    parameter int TIMER_WIDTH = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire t_in              i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_out                  o_data,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int LW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [LW-1:0] TMAX = LW'((64'd1 << TIMER_WIDTH) - 64'd1);

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_WAITHI = 7'b0000010,
        PH_LOW    = 7'b0000100,
        PH_REL    = 7'b0001000,
        PH_SAMPLE = 7'b0010000,
        PH_TAIL   = 7'b0100000,
        PH_FINISH = 7'b1000000
    } t_phase;

    t_cfg w_cfg;

    t_phase                 r_phase,     n_phase;
    logic [TIMER_WIDTH-1:0] r_time_left, n_time_left;
    logic [2:0]             r_cmd,       n_cmd;
    logic [15:0]            r_shift,     n_shift;
    logic [4:0]             r_bits,      n_bits;
    logic                   r_out_valid;
    t_out                   r_out;
    t_out                   w_res;
    logic                   w_accept;

    function automatic logic [TIMER_WIDTH-1:0] tload(input logic [CFG_W-1:0] v);
        logic [LW-1:0] ve;
        ve = LW'(v);
        return (ve > TMAX) ? TIMER_WIDTH'(TMAX) : TIMER_WIDTH'(ve);
    endfunction

    function automatic logic [CFG_W-1:0] sat_sub(input logic [CFG_W-1:0] a,
                                                  input logic [CFG_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    owm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        logic             do_rel;
        logic             do_tail;
        logic             do_end;
        logic [CFG_W-1:0] len;
        logic [CFG_W-1:0] low_len;
        logic [15:0]      top;

        n_phase     = r_phase;
        n_time_left = r_time_left;
        n_cmd       = r_cmd;
        n_shift     = r_shift;
        n_bits      = r_bits;
        w_res       = '0;
        w_res.busy_res = 1'b1;
        do_rel      = 1'b0;
        do_tail     = 1'b0;
        do_end      = 1'b0;
        len         = '0;
        top         = (r_cmd == CMD_RDW) ? 16'h8000 : 16'h0080;

        if (r_cmd == CMD_RESET) begin
            low_len = w_cfg.reset_low_time;
        end else if (r_cmd == CMD_SEND) begin
            low_len = r_shift[0] ? w_cfg.low_time_one : w_cfg.low_time_zero;
        end else begin
            low_len = w_cfg.read_low_time;
        end

        unique case (r_phase)
            PH_IDLE: begin
                if (i_data.op == CMD_RESET || i_data.op == CMD_SEND ||
                    i_data.op == CMD_RDB || i_data.op == CMD_RDW) begin
                    n_cmd   = i_data.op;
                    n_shift = (i_data.op == CMD_SEND) ? {8'h00, i_data.tx_byte} : '0;
                    if (i_data.op == CMD_RESET) begin
                        n_bits = 5'd1;
                    end else if (i_data.op == CMD_RDW) begin
                        n_bits = 5'd16;
                    end else begin
                        n_bits = 5'd8;
                    end
                    n_phase = PH_WAITHI;
                end else begin
                    w_res.busy_res = 1'b0;
                end
            end
            PH_WAITHI: begin
                if (i_data.bus_in) begin
                    n_phase     = PH_LOW;
                    n_time_left = tload(low_len);
                end
            end
            PH_LOW: begin
                w_res.drive_low = 1'b1;
                if (r_time_left <= TIMER_WIDTH'(1)) begin
                    if (r_cmd == CMD_RESET) begin
                        do_rel = 1'b1;
                        len    = w_cfg.presence_wait;
                    end else if (r_cmd == CMD_SEND) begin
                        do_tail = 1'b1;
                        len     = r_shift[0] ? sat_sub(w_cfg.slot_time, w_cfg.low_time_one)
                                             : w_cfg.recovery_time;
                    end else begin
                        do_rel = 1'b1;
                        len    = w_cfg.recovery_time;
                    end
                end else begin
                    n_time_left = r_time_left - TIMER_WIDTH'(1);
                end
            end
            PH_REL: begin
                if (r_time_left <= TIMER_WIDTH'(1)) begin
                    n_phase = PH_SAMPLE;
                end else begin
                    n_time_left = r_time_left - TIMER_WIDTH'(1);
                end
            end
            PH_SAMPLE: begin
                do_tail = 1'b1;
                if (r_cmd == CMD_RESET) begin
                    n_shift = {15'd0, i_data.bus_in};
                    len     = sat_sub(w_cfg.reset_high_time, w_cfg.presence_wait);
                end else begin
                    n_shift = (r_shift >> 1) | (i_data.bus_in ? top : 16'h0000);
                    len     = sat_sub(w_cfg.slot_time, w_cfg.read_low_time);
                end
            end
            PH_TAIL: begin
                if (r_time_left <= TIMER_WIDTH'(1)) begin
                    do_end = 1'b1;
                end else begin
                    n_time_left = r_time_left - TIMER_WIDTH'(1);
                end
            end
            PH_FINISH: begin
                w_res.done_res = 1'b1;
                w_res.rx_data  = (r_cmd == CMD_SEND) ? 16'h0000 : r_shift;
                n_phase        = PH_IDLE;
                n_time_left    = '0;
            end
            default: begin
                w_res.busy_res = 1'b0;
                n_phase        = PH_IDLE;
            end
        endcase

        if (do_rel) begin
            if (len == '0) begin
                n_phase = PH_SAMPLE;
            end else begin
                n_phase     = PH_REL;
                n_time_left = tload(len);
            end
        end

        if (do_tail) begin
            if (len == '0) begin
                do_end = 1'b1;
            end else begin
                n_phase     = PH_TAIL;
                n_time_left = tload(len);
            end
        end

        if (do_end) begin
            if (r_cmd == CMD_SEND) begin
                n_shift = r_shift >> 1;
            end
            n_bits  = r_bits - 5'd1;
            n_phase = (r_bits != 5'd1) ? PH_WAITHI : PH_FINISH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time_left <= '0;
            r_cmd       <= CMD_NONE;
            r_shift     <= '0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_time_left <= n_time_left;
                r_cmd       <= n_cmd;
                r_shift     <= n_shift;
                r_bits      <= n_bits;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[hdl/owm_chk.sv]
// ----------------------------------------------------------------------------
// owm_chk
// Port-level checks of the one-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_chk
    import owm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_out o_data
);

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.done_res |-> o_data.busy_res)
        else $error("Done beat without busy.");

    a_rx_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.done_res |-> o_data.rx_data == 16'h0000)
        else $error("Received data shown outside a done beat.");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.drive_low |-> o_data.busy_res && !o_data.done_res)
        else $error("Line driven low outside an active slot.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("Stalled output beat changed.");

endmodule

bind one_wire_bus_master owm_chk u_owm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
